>>> rtl/assert_macros.svh
// assertion macros included by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/rgb_yuv_pkg.sv
// types, constants and coefficient tables for the rgb to yuv 4:2:0 converter
`timescale 1ns / 1ps
package rgb_yuv_pkg;

    localparam int ROM_W        = 24;
    localparam int SUM_W        = 25;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_W     = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef logic [ROM_W-1:0] t_rom [256];

    // entry v holds floor(milli / 1000 * 256 * v)
    function automatic t_rom build_rom(input longint unsigned milli);
        t_rom            rom;
        longint unsigned prod;
        for (int v = 0; v < 256; v++) begin
            prod   = (milli * 64'd256 * longint'(v)) / 64'd1000;
            rom[v] = ROM_W'(prod);
        end
        return rom;
    endfunction

    localparam t_rom ROM_Y_R  = build_rom(64'd65481);
    localparam t_rom ROM_Y_G  = build_rom(64'd128553);
    localparam t_rom ROM_Y_B  = build_rom(64'd24966);
    localparam t_rom ROM_U_R  = build_rom(64'd37797);
    localparam t_rom ROM_U_G  = build_rom(64'd74203);
    localparam t_rom ROM_V_G  = build_rom(64'd93786);
    localparam t_rom ROM_V_B  = build_rom(64'd18214);
    localparam t_rom ROM_C112 = build_rom(64'd112000);

    localparam logic [SUM_W-1:0] Y_OFFSET = SUM_W'(1048576);
    localparam logic [SUM_W-1:0] C_OFFSET = SUM_W'(8388608);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic eof;
    } t_pos_flags;

endpackage

>>> rtl/rgb24_to_yuv420_converter_top.sv
// top level of the rgb24 to yuv 4:2:0 pixel stream converter
//
//  port group    direction  handshake                  payload
//  pixel in      in         i_pix_valid / o_pix_ready  i_red, i_green, i_blue
//  result out    out        o_res_valid / i_res_ready  o_luma, o_chroma_valid,
//                                                       o_cb_avg, o_cr_avg, o_end_of_frame
//  config write  in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one pixel beat per clock while the result register is not stalled; an accepted pixel beat
//  passes the input stage (with line buffer read), then the result register
//  the line buffer ram read is issued on the input beat and lands with the input stage
//  a stalled result register holds the input stage, which holds o_pix_ready low
//  synchronous reset clears counters, valids and held chroma; line buffers need no clear
`timescale 1ns / 1ps
module rgb24_to_yuv420_converter_top import rgb_yuv_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [7:0]           o_luma,
    output logic                 o_chroma_valid,
    output logic [7:0]           o_cb_avg,
    output logic [7:0]           o_cr_avg,
    output logic                 o_end_of_frame,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

`include "assert_macros.svh"

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic               pix_fire;
    logic               s1_fire;
    logic               out_free;
    t_pos_flags         pos_flags;
    logic [LINE_AW-1:0] pos_idx;

    logic               r_s1_valid;
    logic [7:0]         r_s1_red;
    logic [7:0]         r_s1_green;
    logic [7:0]         r_s1_blue;
    t_pos_flags         r_s1_flags;
    logic [LINE_AW-1:0] r_s1_idx;

    logic [7:0]         r_held_cb;
    logic [7:0]         r_held_cr;

    logic               r_out_valid;
    logic [7:0]         r_out_luma;
    logic               r_out_chroma_valid;
    logic [7:0]         r_out_cb;
    logic [7:0]         r_out_cr;
    logic               r_out_eof;

    logic [7:0]         luma;
    logic [7:0]         cb;
    logic [7:0]         cr;
    logic [8:0]         line_cb;
    logic [8:0]         line_cr;
    logic               line_wr;
    logic [8:0]         pair_cb;
    logic [8:0]         pair_cr;
    logic [10:0]        quad_cb;
    logic [10:0]        quad_cr;
    logic               chroma_out;

    assign out_free    = !r_out_valid || i_res_ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_pix_ready = !r_s1_valid || out_free;
    assign pix_fire    = i_pix_valid && o_pix_ready;
    assign o_cfg_ready = 1'b1;

    rgb_yuv_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (pix_fire),
        .o_flags     (pos_flags),
        .o_idx       (pos_idx)
    );

    rgb_yuv_csc u_csc (
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .o_luma  (luma),
        .o_cb    (cb),
        .o_cr    (cr)
    );

    // even rows store the column pair sum, odd rows read it back
    assign line_wr = s1_fire && r_s1_flags.col_odd && !r_s1_flags.row_odd;
    assign pair_cb = 9'(r_held_cb) + 9'(cb);
    assign pair_cr = 9'(r_held_cr) + 9'(cr);
    assign quad_cb = 11'(line_cb) + 11'(r_held_cb) + 11'(cb);
    assign quad_cr = 11'(line_cr) + 11'(r_held_cr) + 11'(cr);
    assign chroma_out = r_s1_flags.col_odd && r_s1_flags.row_odd;

    rgb_yuv_ram #(
        .WIDTH (9),
        .DEPTH (LINE_DEPTH)
    ) u_cb_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (pair_cb),
        .i_rd_en   (pix_fire),
        .i_rd_addr (pos_idx),
        .o_rd_data (line_cb)
    );

    rgb_yuv_ram #(
        .WIDTH (9),
        .DEPTH (LINE_DEPTH)
    ) u_cr_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (pair_cr),
        .i_rd_en   (pix_fire),
        .i_rd_addr (pos_idx),
        .o_rd_data (line_cr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_cb   <= '0;
            r_held_cr   <= '0;
        end else begin
            if (pix_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire && !r_s1_flags.col_odd) begin
                r_held_cb <= cb;
                r_held_cr <= cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_flags <= pos_flags;
            r_s1_idx   <= pos_idx;
        end
        if (s1_fire) begin
            r_out_luma         <= luma;
            r_out_chroma_valid <= chroma_out;
            r_out_cb           <= chroma_out ? quad_cb[9:2] : 8'd0;
            r_out_cr           <= chroma_out ? quad_cr[9:2] : 8'd0;
            r_out_eof          <= r_s1_flags.eof;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_luma         = r_out_luma;
    assign o_chroma_valid = r_out_chroma_valid;
    assign o_cb_avg       = r_out_cb;
    assign o_cr_avg       = r_out_cr;
    assign o_end_of_frame = r_out_eof;

    `ASSERT_CLK(a_no_chroma_zero, i_clk, i_rst_n, o_res_valid && !o_chroma_valid |-> (o_cb_avg == 8'd0) && (o_cr_avg == 8'd0), "chroma nonzero without chroma_valid")
    `ASSERT_CLK(a_ready_only_on_stall, i_clk, i_rst_n, !o_pix_ready |-> o_res_valid && !i_res_ready, "input held off without an output stall")
    `ASSERT_CLK(a_block_close, i_clk, i_rst_n, s1_fire && r_s1_flags.col_odd && r_s1_flags.row_odd |=> o_res_valid && o_chroma_valid, "odd row odd column beat lost its chroma")
    `ASSERT_CLK(a_line_wr_even_row, i_clk, i_rst_n, line_wr |-> !chroma_out, "line buffer written on a chroma beat")

endmodule

>>> rtl/rgb_yuv_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rgb_yuv_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/rgb_yuv_csc.sv
// bt.601 color space conversion of one pixel from table terms
`timescale 1ns / 1ps
module rgb_yuv_csc import rgb_yuv_pkg::*; (
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma,
    output logic [7:0] o_cb,
    output logic [7:0] o_cr
);

    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;

    // chroma sums stay positive for any 8-bit input
    always_comb begin
        y_sum  = SUM_W'(ROM_Y_R[i_red]) + SUM_W'(ROM_Y_G[i_green])
               + SUM_W'(ROM_Y_B[i_blue]) + Y_OFFSET;
        cb_sum = SUM_W'(ROM_C112[i_blue]) + C_OFFSET
               - SUM_W'(ROM_U_R[i_red]) - SUM_W'(ROM_U_G[i_green]);
        cr_sum = SUM_W'(ROM_C112[i_red]) + C_OFFSET
               - SUM_W'(ROM_V_G[i_green]) - SUM_W'(ROM_V_B[i_blue]);
    end

    assign o_luma = y_sum[23:16];
    assign o_cb   = cb_sum[23:16];
    assign o_cr   = cr_sum[23:16];

endmodule

>>> rtl/rgb_yuv_pos.sv
// frame geometry registers and raster position counters
`timescale 1ns / 1ps
module rgb_yuv_pos import rgb_yuv_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    localparam int LINE_DEPTH = MAX_WIDTH / 2,
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_step,
    output t_pos_flags           o_flags,
    output logic [LINE_AW-1:0]   o_idx
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = CFG_W + 1;
    localparam int RESET_W_EFF = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [EW-1:0]       r_w_eff;
    logic [HEIGHT_W-1:0] r_h_eff;

    logic [CMP_W-1:0]    cfg_even;
    logic [EW-1:0]       w_new;
    logic [HEIGHT_W-1:0] h_new;
    logic                last_col;
    logic                last_row;
    logic [COL_W-1:0]    half;
    logic [COL_W-1:0]    half_wrap;

    // even value, zero taken as two, clipped to the limit
    always_comb begin
        cfg_even = {1'b0, i_cfg_data[CFG_W-1:1], 1'b0};
        if (cfg_even == '0) begin
            w_new = EW'(2);
            h_new = HEIGHT_W'(2);
        end else begin
            w_new = (cfg_even > CMP_W'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(cfg_even);
            h_new = (cfg_even > CMP_W'(HEIGHT_LIMIT)) ? HEIGHT_W'(HEIGHT_LIMIT)
                                                        : HEIGHT_W'(cfg_even);
        end
    end

    always_comb begin
        last_col  = (EW'(r_col) + EW'(1)) >= r_w_eff;
        last_row  = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= r_h_eff;
        half      = r_col >> 1;
        half_wrap = (half >= COL_W'(LINE_DEPTH)) ? (half - COL_W'(LINE_DEPTH)) : half;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_w_eff <= EW'(RESET_W_EFF);
            r_h_eff <= HEIGHT_W'(RESET_HEIGHT);
        end else begin
            if (i_step) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_wr) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_FRAME_WIDTH:  r_w_eff <= w_new;
                    REG_FRAME_HEIGHT: r_h_eff <= h_new;
                    default: ;
                endcase
            end
        end
    end

    assign o_flags.col_odd = r_col[0];
    assign o_flags.row_odd = r_row[0];
    assign o_flags.eof     = last_col && last_row;
    assign o_idx           = LINE_AW'(half_wrap);

endmodule

>>> tb/rgb24_to_yuv420_converter_top_tb.sv
// self-checking testbench for the rgb24 to yuv 4:2:0 converter
`timescale 1ns / 1ps

import rgb_yuv_pkg::*;

typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_avg;
    logic [7:0] cr_avg;
    logic       end_of_frame;
} t_yuv_beat;

// tracks the pixel position, line pair sums and geometry; queues the expected yuv beats
class ycbcr420_tracker;
    localparam int unsigned K_YR       = 65481;
    localparam int unsigned K_YG       = 128553;
    localparam int unsigned K_YB       = 24966;
    localparam int unsigned K_UR       = 37797;
    localparam int unsigned K_UG       = 74203;
    localparam int unsigned K_VG       = 93786;
    localparam int unsigned K_VB       = 18214;
    localparam int unsigned K_C112     = 112000;
    localparam int unsigned Y_BIAS     = 32'd16 << 16;
    localparam int unsigned C_BIAS     = 32'd128 << 16;
    localparam int unsigned LINE_SLOTS = 2048;
    localparam int unsigned SIZE_LIMIT = 4096;

    bit [8:0]         cb_pair [LINE_SLOTS];
    bit [8:0]         cr_pair [LINE_SLOTS];
    bit [7:0]         held_cb;
    bit [7:0]         held_cr;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_yuv_beat        pending_yuv[$];
    int unsigned      mismatch_count;

    function new();
        held_cb        = '0;
        held_cr        = '0;
        col_pos        = 0;
        row_pos        = 0;
        width_reg      = 13'd640;
        height_reg     = 13'd480;
        mismatch_count = 0;
    endfunction

    // floor(milli / 1000 * 256 * v)
    static function int unsigned coef_term(int unsigned milli, logic [7:0] v);
        longint unsigned p;
        p = 64'(milli) * 64'd256 * 64'(v);
        return 32'(p / 64'd1000);
    endfunction

    static function int unsigned span(logic [CFG_W-1:0] raw);
        int unsigned e;
        e = 32'(raw & 13'h1FFE);
        if (e == 0) e = 2;
        if (e > SIZE_LIMIT) e = SIZE_LIMIT;
        return e;
    endfunction

    function void write_reg(t_cfg_reg which, logic [CFG_W-1:0] value);
        case (which)
            REG_FRAME_WIDTH:  width_reg  = value;
            REG_FRAME_HEIGHT: height_reg = value;
            default: ;
        endcase
    endfunction

    function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned y, cb, cr, w, h, slot;
        bit          last_col, last_row;
        t_yuv_beat   want;
        w = span(width_reg);
        h = span(height_reg);
        y  = (coef_term(K_YR, r) + coef_term(K_YG, g) + coef_term(K_YB, b) + Y_BIAS) >> 16;
        cb = (coef_term(K_C112, b) + C_BIAS - coef_term(K_UR, r) - coef_term(K_UG, g)) >> 16;
        cr = (coef_term(K_C112, r) + C_BIAS - coef_term(K_VG, g) - coef_term(K_VB, b)) >> 16;
        cb = cb & 32'hFF;
        cr = cr & 32'hFF;
        want      = '0;
        want.luma = y[7:0];
        slot = (col_pos >> 1) % LINE_SLOTS;
        if ((col_pos & 1) == 0) begin
            held_cb = cb[7:0];
            held_cr = cr[7:0];
        end else if ((row_pos & 1) == 0) begin
            cb_pair[slot] = 9'((held_cb + cb) & 32'h1FF);
            cr_pair[slot] = 9'((held_cr + cr) & 32'h1FF);
        end else begin
            want.chroma_valid = 1'b1;
            want.cb_avg = 8'((cb_pair[slot] + held_cb + cb) >> 2);
            want.cr_avg = 8'((cr_pair[slot] + held_cr + cr) >> 2);
        end
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        want.end_of_frame = last_col && last_row;
        pending_yuv.push_back(want);
        // a counter past a shrunk geometry wraps just like at the last column or row
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        mismatch_count++;
    endfunction

    function void match_result(t_yuv_beat got);
        t_yuv_beat want;
        if (pending_yuv.size() == 0) begin
            $display("%0t: unexpected beat, expected none got luma %0d chroma %0d cb %0d cr %0d eof %0d",
                     $time, got.luma, got.chroma_valid, got.cb_avg, got.cr_avg, got.end_of_frame);
            mismatch_count++;
            return;
        end
        want = pending_yuv.pop_front();
        if (got.luma !== want.luma) flag("luma", want.luma, got.luma);
        if (got.chroma_valid !== want.chroma_valid)
            flag("chroma_valid", 8'(want.chroma_valid), 8'(got.chroma_valid));
        if (got.cb_avg !== want.cb_avg) flag("cb_avg", want.cb_avg, got.cb_avg);
        if (got.cr_avg !== want.cr_avg) flag("cr_avg", want.cr_avg, got.cr_avg);
        if (got.end_of_frame !== want.end_of_frame)
            flag("end_of_frame", 8'(want.end_of_frame), 8'(got.end_of_frame));
    endfunction
endclass

module rgb24_to_yuv420_converter_top_tb;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    // black, white, red, blue, green, mid grey: one per column pair
    localparam logic [23:0] SWATCHES [6] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF, 24'h00FF00, 24'h808080
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_pix_valid;
    logic                 o_pix_ready;
    logic [7:0]           i_red;
    logic [7:0]           i_green;
    logic [7:0]           i_blue;
    logic                 o_res_valid;
    logic                 i_res_ready = 1'b0;
    logic [7:0]           o_luma;
    logic                 o_chroma_valid;
    logic [7:0]           o_cb_avg;
    logic [7:0]           o_cr_avg;
    logic                 o_end_of_frame;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    ycbcr420_tracker converter = new();

    bit          quiet_phase  = 1'b0;
    int unsigned burst_left   = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    t_rx_mode    rx_mode      = RX_STEADY;
    int unsigned rx_mode_left = 0;

    rgb24_to_yuv420_converter_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_pix_valid),
        .o_pix_ready    (o_pix_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_cb_avg       (o_cb_avg),
        .o_cr_avg       (o_cr_avg),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: check the beat seen at this edge, then pick ready for the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            converter.match_result({o_luma, o_chroma_valid, o_cb_avg, o_cr_avg, o_end_of_frame});
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 400);
        end else begin
            rx_mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = $urandom_range(200, 400);
            i_res_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: i_res_ready <= 1'b1;
                RX_COIN:   i_res_ready <= 1'($urandom_range(0, 1));
                RX_LIGHT:  i_res_ready <= ($urandom_range(0, 3) != 0);
                default:   i_res_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (!quiet_phase && burst_left == 0) begin
            i_pix_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left != 0) burst_left--;
        i_pix_valid <= 1'b1;
        i_red       <= r;
        i_green     <= g;
        i_blue      <= b;
        do @(posedge i_clk); while (!o_pix_ready);
        converter.take_pixel(r, g, b);
    endtask

    // keeps going past min_count until the next pixel starts an even row position,
    // so the following geometry change never exposes an unwritten line slot
    task automatic send_run(input int unsigned min_count, input bit swatched,
                            output int unsigned sent);
        logic [23:0] rgb;
        sent = 0;
        while (sent < min_count || (converter.row_pos & 1) != 0) begin
            if (swatched && converter.col_pos < 12)
                rgb = SWATCHES[converter.col_pos >> 1];
            else
                rgb = {pick_level(), pick_level(), pick_level()};
            send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
            sent++;
        end
    endtask

    task automatic drain();
        i_pix_valid <= 1'b0;
        while (converter.pending_yuv.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_geometry(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= w_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        converter.write_reg(REG_FRAME_WIDTH, w_raw);
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data  <= h_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        converter.write_reg(REG_FRAME_HEIGHT, h_raw);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned      random_items;
        int unsigned      sent;
        int unsigned      target;
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        i_rst_n     = 1'b0;
        i_pix_valid = 1'b0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_FRAME_WIDTH;
        i_cfg_data  = '0;
        random_items = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: two full rows, solid 2x2 swatches first, output held off early
        hold_request = 1'b1;
        quiet_phase  = 1'b1;
        send_run(1280, 1'b1, sent);
        drain();

        // zero width and height both fall back to 2
        quiet_phase = 1'b0;
        program_geometry(13'd0, 13'd1);
        send_run(8, 1'b0, sent);
        drain();

        // widen to 8x8, then shrink width and height mid-frame, with the column counter past the new edge
        program_geometry(13'd9, 13'd8);
        send_run(4, 1'b0, sent);
        drain();
        program_geometry(13'd4, 13'd2);
        send_run(8, 1'b0, sent);
        drain();

        // oversized registers saturate to the limits
        program_geometry(13'h1FFF, 13'h1FFF);
        send_run(16, 1'b0, sent);
        drain();

        while (random_items < 500) begin
            w_raw = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(41, 200))
                                                : 13'($urandom_range(0, 40));
            h_raw = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(4097, 8191))
                                                : 13'($urandom_range(0, 12));
            program_geometry(w_raw, h_raw);
            quiet_phase = ($urandom_range(0, 3) == 0);
            target = $urandom_range(1, 200);
            if ($urandom_range(0, 11) == 0) begin
                hold_request = 1'b1;
                target += 100;
            end
            send_run(target, 1'b0, sent);
            random_items += sent;
            drain();
        end

        if (converter.mismatch_count == 0 && converter.pending_yuv.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
